// ----- design/sefr_pkg.sv -----
// Package for the STX/ETX frame receiver: item types, frame markers, status codes
// and buffer sizing constants. It depends on nothing else.
`timescale 1ns / 1ps

package sefr_pkg;

  // Receive buffer size in bytes; a frame attempt reaching this many bytes overflows.
  localparam int BufferBytes = 512;
  // Width of the held-byte counter: it never holds more than BufferBytes - 1.
  localparam int HeldW       = $clog2(BufferBytes);
  localparam int CountW      = 9;
  localparam int ElapsedW    = 17;
  localparam int LimitW      = 16;

  localparam logic [7:0] StartMark = 8'h02;
  localparam logic [7:0] EndMark   = 8'h03;
  localparam logic [HeldW:0] MinFrame = (HeldW + 1)'(5);
  localparam logic [HeldW:0] BufLimit = (HeldW + 1)'(BufferBytes);
  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};
  localparam logic [LimitW-1:0] LimitReset = LimitW'(1000);

  // Input kinds.
  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

  // Result item types.
  localparam logic TypePayload = 1'b0;
  localparam logic TypeEnd     = 1'b1;

  // End status codes.
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatChecksum = 2'd1;
  localparam logic [1:0] StatTimeout  = 2'd2;
  localparam logic [1:0] StatOverflow = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              item_type;
    logic [7:0]        payload_byte;
    logic [1:0]        status;
    logic [7:0]        station_address;
    logic [7:0]        function_code;
    logic [CountW-1:0] payload_count;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

// ----- design/stx_etx_frame_receiver_xor.sv -----
// Top level of the STX/ETX frame receiver with XOR checksum.
// Depends on sefr_pkg, sefr_core and sefr_out_fifo.
`timescale 1ns / 1ps

// The receiver takes one item per clock cycle, either a received UART byte or a
// millisecond tick, and writes at most one result item for it into the result
// buffer. Every input item is handled by combinational decoding logic, whose
// state registers feed straight back for the next item, so input items may
// arrive back to back. Results pass through a two-entry buffer: the input side
// stalls only when both entries wait to be taken by the result channel. A frame
// is 0x02, address, function, payload, XOR checksum and 0x03; payload bytes are
// sent one byte late, so the checksum never appears as payload, and each attempt
// closes with one end item carrying address, function, payload length and status
// (ok, checksum error, timeout or overflow). The timeout limit in milliseconds is
// written through the configuration port and should only be changed while the
// receiver is idle.

module stx_etx_frame_receiver_xor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sefr_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sefr_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [sefr_pkg::LimitW-1:0] cfg_wdata
);
  import sefr_pkg::*;

  logic    accept;
  result_t result;
  logic    buf_full;

  // An item is taken whenever the result buffer has room for what it may cause.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  sefr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  sefr_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- design/sefr_core.sv -----
// Frame decoding state and per-item decision logic of the frame receiver.
// Depends on sefr_pkg.
`timescale 1ns / 1ps

module sefr_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  sefr_pkg::in_item_t          in_item,
  input  logic                        cfg_we,
  input  logic [sefr_pkg::LimitW-1:0] cfg_wdata,
  output sefr_pkg::result_t           result
);
  import sefr_pkg::*;

  logic [LimitW-1:0]   limit_r;
  logic [HeldW-1:0]    held_r, held_nxt;
  logic [7:0]          xor_r, xor_nxt;
  logic                began_r, began_nxt;
  logic [7:0]          pending_r, pending_nxt;
  logic [7:0]          addr_r, addr_nxt;
  logic [7:0]          func_r, func_nxt;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt;

  logic [HeldW:0]      n1;
  logic [HeldW:0]      frame_len;
  logic [ElapsedW-1:0] elapsed_inc;
  logic                bws;
  logic [7:0]          addr_upd, func_upd;
  logic                timed_out;
  logic                end_item;
  logic [7:0]          b;

  always_comb begin
    b           = in_item.rx_byte;
    n1          = {1'b0, held_r} + (HeldW + 1)'(1);
    frame_len   = n1 - MinFrame;
    elapsed_inc = (elapsed_r == ElapsedMax) ? elapsed_r : elapsed_r + ElapsedW'(1);
    bws         = (held_r == '0) ? (b == StartMark) : began_r;
    addr_upd    = (held_r == HeldW'(1)) ? b : addr_r;
    func_upd    = (held_r == HeldW'(2)) ? b : func_r;
    timed_out   = elapsed_r > {{(ElapsedW - LimitW){1'b0}}, limit_r};

    held_nxt    = held_r;
    xor_nxt     = xor_r;
    began_nxt   = began_r;
    pending_nxt = pending_r;
    addr_nxt    = addr_r;
    func_nxt    = func_r;
    elapsed_nxt = elapsed_r;
    end_item    = 1'b0;
    result      = '0;

    unique case (in_item.kind)
      KindTick: begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > {{(ElapsedW - LimitW){1'b0}}, limit_r}) begin
          end_item                    = 1'b1;
          result.item.status          = StatTimeout;
          result.item.station_address = addr_r;
          result.item.function_code   = func_r;
        end
      end
      KindByte: begin
        priority if (bws && n1 >= MinFrame && b == EndMark) begin
          end_item                  = 1'b1;
          result.item.status        = (xor_r == 8'h00) ? StatOk : StatChecksum;
          result.item.payload_count = frame_len[CountW-1:0];
        end else if (timed_out) begin
          end_item           = 1'b1;
          result.item.status = StatTimeout;
        end else if (n1 >= BufLimit) begin
          end_item           = 1'b1;
          result.item.status = StatOverflow;
        end else begin
          if (held_r != '0) begin
            xor_nxt = xor_r ^ b;
          end
          if (bws && held_r >= HeldW'(4)) begin
            result.valid             = 1'b1;
            result.item.item_type    = TypePayload;
            result.item.payload_byte = pending_r;
          end
          pending_nxt = b;
          held_nxt    = n1[HeldW-1:0];
          began_nxt   = bws;
          addr_nxt    = addr_upd;
          func_nxt    = func_upd;
        end
        if (end_item) begin
          result.item.station_address = addr_upd;
          result.item.function_code   = func_upd;
        end
      end
      default: ;
    endcase

    if (end_item) begin
      result.valid          = 1'b1;
      result.item.item_type = TypeEnd;
      held_nxt    = '0;
      xor_nxt     = '0;
      began_nxt   = 1'b0;
      pending_nxt = '0;
      addr_nxt    = '0;
      func_nxt    = '0;
      elapsed_nxt = '0;
    end
    if (!accept) begin
      result.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r   <= LimitReset;
      held_r    <= '0;
      xor_r     <= '0;
      began_r   <= 1'b0;
      pending_r <= '0;
      addr_r    <= '0;
      func_r    <= '0;
      elapsed_r <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        held_r    <= held_nxt;
        xor_r     <= xor_nxt;
        began_r   <= began_nxt;
        pending_r <= pending_nxt;
        addr_r    <= addr_nxt;
        func_r    <= func_nxt;
        elapsed_r <= elapsed_nxt;
      end
    end
  end

endmodule

// ----- design/sefr_out_fifo.sv -----
// Two-entry result buffer that parts the decoder from the result channel.
// Depends on sefr_pkg.
`timescale 1ns / 1ps

module sefr_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  sefr_pkg::result_t   push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output sefr_pkg::out_item_t out_item
);
  import sefr_pkg::*;

  out_item_t  mem_r [2];
  logic       head_r, head_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       tail;
  logic       pop;

  always_comb begin
    full      = (cnt_r == 2'd2);
    out_valid = (cnt_r != 2'd0);
    out_item  = mem_r[head_r];
    pop       = out_valid && !out_stall;
    tail      = head_r ^ cnt_r[0];
    head_nxt  = pop ? ~head_r : head_r;
    cnt_nxt   = cnt_r + {1'b0, push.valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[tail] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- dv/sefr_frame_tracker_pkg.sv -----
// Frame tracker for the STX/ETX receiver bench: predicts the result items of the
// receiver and checks the ones that arrive. Depends on sefr_pkg.
`timescale 1ns / 1ps

package sefr_frame_tracker_pkg;

  import sefr_pkg::*;

  class frame_tracker;

    logic [LimitW-1:0]   limit_ms;
    logic [HeldW:0]      held;
    logic [7:0]          xor_acc;
    logic                started;
    logic [7:0]          last_byte;
    logic [7:0]          addr;
    logic [7:0]          func;
    logic [ElapsedW-1:0] elapsed;

    out_item_t   awaited[$];
    int unsigned errors;
    int unsigned inputs_seen;
    int unsigned payloads_seen;
    int unsigned ends_seen[4];

    function new();
      limit_ms = LimitReset;
      errors = 0;
      inputs_seen = 0;
      payloads_seen = 0;
      foreach (ends_seen[i]) ends_seen[i] = 0;
      restart();
    endfunction

    function void restart();
      held = '0;
      xor_acc = '0;
      started = 1'b0;
      last_byte = '0;
      addr = '0;
      func = '0;
      elapsed = '0;
    endfunction

    function void set_limit(logic [LimitW-1:0] value);
      limit_ms = value;
    endfunction

    // Every attempt finishes with one end item, after which all frame state clears.
    function void close_attempt(logic [1:0] stat, logic [HeldW:0] count);
      out_item_t r;
      r = '0;
      r.item_type = TypeEnd;
      r.status = stat;
      r.station_address = addr;
      r.function_code = func;
      r.payload_count = count[CountW-1:0];
      awaited.push_back(r);
      restart();
    endfunction

    function void take_input(in_item_t it);
      logic [HeldW:0] n1;
      out_item_t      r;
      inputs_seen++;
      if (it.kind == KindTick) begin
        if (elapsed != ElapsedMax) elapsed++;
        if (elapsed > limit_ms) close_attempt(StatTimeout, '0);
        return;
      end
      if (held == 0) started = (it.rx_byte == StartMark);
      else if (held == 1) addr = it.rx_byte;
      else if (held == 2) func = it.rx_byte;
      n1 = held + 1'b1;
      if (started && n1 >= MinFrame && it.rx_byte == EndMark) begin
        close_attempt((xor_acc == 8'h00) ? StatOk : StatChecksum, n1 - MinFrame);
      end else if (elapsed > limit_ms) begin
        close_attempt(StatTimeout, '0);
      end else if (n1 >= BufLimit) begin
        close_attempt(StatOverflow, '0);
      end else begin
        if (held != 0) xor_acc ^= it.rx_byte;
        // Payload runs one byte behind, so the checksum never leaves as payload.
        if (started && held >= 4) begin
          r = '0;
          r.item_type = TypePayload;
          r.payload_byte = last_byte;
          awaited.push_back(r);
        end
        last_byte = it.rx_byte;
        held = n1;
      end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      if (want.item_type == TypeEnd) ends_seen[want.status]++;
      else payloads_seen++;
      compare_field("item_type", 16'(want.item_type), 16'(got.item_type));
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("station_address", 16'(want.station_address),
                    16'(got.station_address));
      compare_field("function_code", 16'(want.function_code), 16'(got.function_code));
      compare_field("payload_count", 16'(want.payload_count), 16'(got.payload_count));
    endfunction

  endclass

endpackage

// ----- dv/stx_etx_frame_receiver_xor_test.sv -----
// Bench for the STX/ETX frame receiver: directed frames, boundary lengths and
// random traffic phases, checked against a frame tracker. Depends on sefr_pkg,
// sefr_frame_tracker_pkg and the receiver RTL.
`timescale 1ns / 1ps

module stx_etx_frame_receiver_xor_test;

  import sefr_pkg::*;
  import sefr_frame_tracker_pkg::*;

  typedef logic [7:0] byte_seq_t[$];

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_item;
  logic                cfg_we;
  logic [LimitW-1:0]   cfg_wdata;

  frame_tracker tracker;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int idle_pct;
  int stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_request;

  stx_etx_frame_receiver_xor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A hard stop, well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("stx_etx_frame_receiver_xor verification failed");
    $finish;
  end

  // Both channels are sampled at the clock edge, before any of this edge's
  // updates land. Results are checked first, so an item accepted at the same
  // edge can never be mistaken for the owner of a result that is already out.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.match_result(out_item);
      if (in_valid && !in_stall) tracker.take_input(in_item);
    end
  end

  // The result side. Stalls are drawn afresh each cycle, except during the one
  // long hold-off, which is counted out here while the sender keeps offering
  // items, so that the result buffer fills and the input side stalls.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (300) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic in_item_t byte_item(logic [7:0] b);
    in_item_t it;
    it.kind = KindByte;
    it.rx_byte = b;
    return it;
  endfunction

  // The byte field of a tick is ignored by the receiver, so it carries noise.
  function automatic in_item_t tick_item();
    in_item_t it;
    it.kind = KindTick;
    it.rx_byte = 8'($urandom);
    return it;
  endfunction

  // Offers one item and returns at the edge where it is taken. Idle cycles are
  // drawn before the item, so they fall between any two items of a frame.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic emit_byte(input logic [7:0] b, input int tick_pct);
    if ($urandom_range(99) < tick_pct) send_item(tick_item());
    send_item(byte_item(b));
  endtask

  task automatic send_seq(input byte_seq_t seq);
    foreach (seq[i]) send_item(byte_item(seq[i]));
  endtask

  // One frame with random address, function and payload. The payload avoids the
  // end marker so that the frame runs to its full length; a frame left
  // unfinished is swallowed by whatever follows it.
  task automatic send_frame(input int plen, input bit good_sum, input bit finish,
                            input int tick_pct);
    logic [7:0] a;
    logic [7:0] f;
    logic [7:0] p;
    logic [7:0] sum;
    a = 8'($urandom);
    f = 8'($urandom);
    sum = a ^ f;
    emit_byte(StartMark, tick_pct);
    emit_byte(a, tick_pct);
    emit_byte(f, tick_pct);
    for (int i = 0; i < plen; i++) begin
      p = 8'($urandom);
      if (p == EndMark) p = 8'hC3;
      sum ^= p;
      emit_byte(p, tick_pct);
    end
    if (finish) begin
      if (!good_sum) sum ^= 8'($urandom_range(1, 255));
      emit_byte(sum, tick_pct);
      emit_byte(EndMark, tick_pct);
    end
  endtask

  // Stops offering items and waits for every predicted result. The first edge
  // lets the monitor take note of the last accepted item; the trailing cycles
  // cover items that produce no result but may still be in the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The register is only written while nothing is in flight.
  task automatic write_limit(input logic [LimitW-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_limit(value);
  endtask

  // One traffic phase. Most of it is well-formed frames with random content,
  // some with a bad checksum. With a short timeout the rest is noise, bad starts,
  // truncated frames and runs of ticks, which clear them again; with a long one
  // only truncated frames and runs of ticks are mixed in, because a bad start
  // would then hold the receiver until the buffer overflows.
  task automatic run_phase(input int idle, input int stall, input int limit_value,
                           input int target, input int tick_pct, input bit hold);
    int         first;
    int         pick;
    logic [7:0] nb;
    drain();
    write_limit(LimitW'(limit_value));
    idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_request = 1'b1;
    first = tracker.inputs_seen;
    while (tracker.inputs_seen - first < target) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send_frame(($urandom_range(9) < 8) ? $urandom_range(0, 12) : $urandom_range(13, 40),
                   $urandom_range(99) < 80, 1'b1, tick_pct);
      end else if (pick < 76 && limit_value <= 50) begin
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(3))
            0: nb = StartMark;
            1: nb = EndMark;
            default: nb = 8'($urandom);
          endcase
          emit_byte(nb, tick_pct);
        end
      end else if (pick < 88) begin
        send_frame($urandom_range(0, 6), 1'b1, 1'b0, tick_pct);
      end else begin
        repeat ($urandom_range(1, 12)) send_item(tick_item());
      end
    end
  endtask

  initial begin
    tracker = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A minimal frame with the byte extremes, then a frame whose
    // address and function are end markers held too early to close it, with a
    // checksum that does not cancel.
    write_limit(LimitW'(1000));
    send_seq('{StartMark, 8'hFF, 8'h00, 8'hFF, EndMark});
    send_seq('{StartMark, EndMark, EndMark, 8'h80, 8'h81, EndMark});
    // A zero limit times out on the very first tick; a bad first byte keeps the
    // following end markers from closing anything, so only the tick ends it.
    drain();
    write_limit('0);
    send_item(tick_item());
    send_seq('{8'h00, EndMark, EndMark, EndMark, EndMark, EndMark});
    send_item(tick_item());
    // Ticks gathered under a long limit, then the limit lowered: the next byte
    // itself brings the timeout end.
    drain();
    write_limit('1);
    send_item(byte_item(StartMark));
    repeat (3) send_item(tick_item());
    drain();
    write_limit(LimitW'(1));
    send_item(byte_item(8'h11));

    // Boundary length: a started frame that fills the buffer and overflows.
    drain();
    write_limit('1);
    send_frame(BufferBytes - 3, 1'b1, 1'b0, 0);

    // Random traffic under the four idling patterns and a spread of limits.
    run_phase(0, 0, 20, 20, 4, 1'b0);
    run_phase(73, 0, 0, 20, 2, 1'b0);
    run_phase(0, 73, 65535, 20, 5, 1'b0);
    run_phase(18, 18, 7, 20, 3, 1'b0);
    run_phase(0, 0, 1000, 20, 3, 1'b1);
    run_phase(0, 0, 3, 20, 3, 1'b0);

    drain();
    $display("Ran %0d input items: directed frames, a 512-byte overflow frame and six",
             tracker.inputs_seen);
    $display("random phases; %0d payload bytes, ends ok/checksum/timeout/overflow %0d/%0d/%0d/%0d.",
             tracker.payloads_seen, tracker.ends_seen[StatOk], tracker.ends_seen[StatChecksum],
             tracker.ends_seen[StatTimeout], tracker.ends_seen[StatOverflow]);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("stx_etx_frame_receiver_xor verification clean");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived", $time, tracker.errors,
               tracker.awaited.size());
      $display("stx_etx_frame_receiver_xor verification failed");
    end
    $finish;
  end

endmodule

// ----- stx_etx_frame_receiver_xor.f -----
design/sefr_pkg.sv
design/sefr_core.sv
design/sefr_out_fifo.sv
design/stx_etx_frame_receiver_xor.sv
dv/sefr_frame_tracker_pkg.sv
dv/stx_etx_frame_receiver_xor_test.sv
